// ----- rtl/sgr_pkg.sv -----
package sgr_pkg;

	// Screen and glyph geometry.
	localparam int SCREEN_W    = 240;
	localparam int SCREEN_H    = 240;
	localparam int GLYPH_COLS  = 5;
	localparam int GLYPH_ROWS  = 7;
	localparam int GLYPH_BITS  = GLYPH_COLS * GLYPH_ROWS;
	localparam int COL_AW      = $clog2(GLYPH_COLS);
	localparam int ROW_W       = $clog2(GLYPH_ROWS);

	// Field widths.
	localparam int CODE_W  = 8;
	localparam int ORG_W   = 10;
	localparam int SCALE_W = 4;
	localparam int COLOR_W = 16;
	localparam int COORD_W = 8;
	// Working width of signed positions: origin plus six dots plus one square.
	localparam int POS_W   = 12;

	localparam logic [SCALE_W-1:0] MAX_SCALE = SCALE_W'(8);
	localparam logic [COL_AW-1:0]  LAST_COL  = COL_AW'(GLYPH_COLS - 1);
	localparam logic [ROW_W-1:0]   LAST_ROW  = ROW_W'(GLYPH_ROWS - 1);

	// Character codes used by the case fold.
	localparam logic [CODE_W-1:0] CHAR_LOWER_A = 8'h61;
	localparam logic [CODE_W-1:0] CHAR_LOWER_Z = 8'h7A;
	localparam logic [CODE_W-1:0] CASE_OFFSET  = 8'h20;

	// Clipped span of one square along one axis.
	typedef struct packed {
		logic               vis;
		logic [COORD_W-1:0] lo;
		logic [SCALE_W-1:0] len;
	} span_t;

	// Font ROM: columns packed as {col4, col3, col2, col1, col0}, bit 0 is the top row.
	function automatic logic [GLYPH_BITS-1:0] glyph_bits(input logic [CODE_W-1:0] code);
		logic [GLYPH_BITS-1:0] g;
		case (code)
			"0":     g = {7'h3E, 7'h45, 7'h49, 7'h51, 7'h3E};
			"1":     g = {7'h00, 7'h40, 7'h7F, 7'h42, 7'h00};
			"2":     g = {7'h46, 7'h49, 7'h51, 7'h61, 7'h42};
			"3":     g = {7'h31, 7'h4B, 7'h45, 7'h41, 7'h21};
			"4":     g = {7'h10, 7'h7F, 7'h12, 7'h14, 7'h18};
			"5":     g = {7'h39, 7'h45, 7'h45, 7'h45, 7'h27};
			"6":     g = {7'h30, 7'h49, 7'h49, 7'h4A, 7'h3C};
			"7":     g = {7'h03, 7'h05, 7'h09, 7'h71, 7'h01};
			"8":     g = {7'h36, 7'h49, 7'h49, 7'h49, 7'h36};
			"9":     g = {7'h1E, 7'h29, 7'h49, 7'h49, 7'h06};
			"A":     g = {7'h7E, 7'h11, 7'h11, 7'h11, 7'h7E};
			"E":     g = {7'h41, 7'h49, 7'h49, 7'h49, 7'h7F};
			"F":     g = {7'h01, 7'h09, 7'h09, 7'h09, 7'h7F};
			"H":     g = {7'h7F, 7'h08, 7'h08, 7'h08, 7'h7F};
			"I":     g = {7'h00, 7'h41, 7'h7F, 7'h41, 7'h00};
			"L":     g = {7'h40, 7'h40, 7'h40, 7'h40, 7'h7F};
			"P":     g = {7'h06, 7'h09, 7'h09, 7'h09, 7'h7F};
			"S":     g = {7'h31, 7'h49, 7'h49, 7'h49, 7'h46};
			"T":     g = {7'h01, 7'h01, 7'h7F, 7'h01, 7'h01};
			"W":     g = {7'h7F, 7'h20, 7'h18, 7'h20, 7'h7F};
			"K":     g = {7'h41, 7'h22, 7'h14, 7'h08, 7'h7F};
			"R":     g = {7'h46, 7'h29, 7'h19, 7'h09, 7'h7F};
			"N":     g = {7'h7F, 7'h10, 7'h0C, 7'h02, 7'h7F};
			" ":     g = {7'h00, 7'h00, 7'h00, 7'h00, 7'h00};
			":":     g = {7'h00, 7'h00, 7'h36, 7'h36, 7'h00};
			".":     g = {7'h00, 7'h00, 7'h60, 7'h60, 7'h00};
			"-":     g = {7'h08, 7'h08, 7'h08, 7'h08, 7'h08};
			"#":     g = {7'h14, 7'h7F, 7'h14, 7'h7F, 7'h14};
			// Codes not in the font draw a hollow box.
			default: g = {7'h7F, 7'h41, 7'h41, 7'h41, 7'h7F};
		endcase
		return g;
	endfunction

	// One column of a glyph.
	function automatic logic [GLYPH_ROWS-1:0] glyph_col(input logic [CODE_W-1:0] code,
		input logic [COL_AW-1:0] col);
		logic [GLYPH_BITS-1:0] g;
		g = glyph_bits(code);
		return g[GLYPH_ROWS*int'(col) +: GLYPH_ROWS];
	endfunction

endpackage

// ----- rtl/sgr_if.sv -----
// Draw request channel.
interface sgr_req_if;
	import sgr_pkg::*;
	logic                      valid;
	logic                      ready;
	logic [CODE_W-1:0]         char_code;
	logic signed [ORG_W-1:0]   origin_x;
	logic signed [ORG_W-1:0]   origin_y;
	logic [SCALE_W-1:0]        scale;
	logic [COLOR_W-1:0]        color;

	modport source (output valid, char_code, origin_x, origin_y, scale, color, input ready);
	modport sink   (input valid, char_code, origin_x, origin_y, scale, color, output ready);
endinterface

// Rectangle result channel.
interface sgr_rsp_if;
	import sgr_pkg::*;
	logic               valid;
	logic               ready;
	logic [COORD_W-1:0] rect_x;
	logic [COORD_W-1:0] rect_y;
	logic [SCALE_W-1:0] rect_w;
	logic [SCALE_W-1:0] rect_h;
	logic [COLOR_W-1:0] fill_color;
	logic               last;

	modport source (output valid, rect_x, rect_y, rect_w, rect_h, fill_color, last,
		input ready);
	modport sink   (input valid, rect_x, rect_y, rect_w, rect_h, fill_color, last,
		output ready);
endinterface

// ----- rtl/sgr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module sgr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ----- rtl/sgr_clip.sv -----
// Clips the span [start, start+len) to [0, limit).
module sgr_clip
	import sgr_pkg::*;
(
	input  logic signed [POS_W-1:0] start,
	input  logic [SCALE_W-1:0]      len,
	input  logic signed [POS_W-1:0] limit,
	output span_t                   span
);
	logic signed [POS_W-1:0] lo_pos;
	logic signed [POS_W-1:0] hi_pos;
	logic signed [POS_W-1:0] hi_clip;
	logic signed [POS_W-1:0] diff;

	always_comb begin
		lo_pos  = start[POS_W-1] ? '0 : start;
		hi_pos  = start + signed'({{(POS_W-SCALE_W){1'b0}}, len});
		hi_clip = (hi_pos > limit) ? limit : hi_pos;
		diff    = hi_clip - lo_pos;
		span.vis = (diff > 0);
		span.lo  = lo_pos[COORD_W-1:0];
		span.len = diff[SCALE_W-1:0];
	end
endmodule

// ----- rtl/scaled_glyph_rect_generator.sv -----
// Draws one 5x7 font character as a list of filled squares. A request is taken only
// while the block is idle; it then writes the five glyph columns into a small column
// RAM, scans the 35 dots one per cycle reading a column from that RAM (a visible dot
// stalls while the held square cannot move out), and closes in a done state that hands
// over the final square with last set, or an all-zero square with last set when nothing
// is visible. Ready returns only once the done state has handed over its result, so a
// new character is not taken before the last one is through. One visible square is
// held back so that last can be set on the final one.
module scaled_glyph_rect_generator
	import sgr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	sgr_req_if.sink   req,
	sgr_rsp_if.source rsp
);
	typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_SCAN, ST_DONE} state_t;

	state_t                  state_q;
	logic [CODE_W-1:0]       code_q;
	logic signed [POS_W-1:0] oy_q;
	logic signed [POS_W-1:0] px_q;
	logic signed [POS_W-1:0] py_q;
	logic [SCALE_W-1:0]      scale_q;
	logic [COLOR_W-1:0]      color_q;
	logic [COL_AW-1:0]       ld_q;
	logic [COL_AW-1:0]       cx_q;
	logic [ROW_W-1:0]        cy_q;

	// Held-back square and output register.
	logic                    pend_v_q;
	logic [COORD_W-1:0]      pend_x_q;
	logic [COORD_W-1:0]      pend_y_q;
	logic [SCALE_W-1:0]      pend_w_q;
	logic [SCALE_W-1:0]      pend_h_q;
	logic                    out_v_q;
	logic [COORD_W-1:0]      out_x_q;
	logic [COORD_W-1:0]      out_y_q;
	logic [SCALE_W-1:0]      out_w_q;
	logic [SCALE_W-1:0]      out_h_q;
	logic [COLOR_W-1:0]      out_c_q;
	logic                    out_last_q;

	logic [GLYPH_ROWS-1:0]   col_data;
	logic                    ram_re;
	logic [COL_AW-1:0]       ram_raddr;
	span_t                   span_x;
	span_t                   span_y;
	logic                    hit;
	logic                    out_free;
	logic                    out_load;
	logic                    advance;
	logic [CODE_W-1:0]       req_code;
	logic signed [POS_W-1:0] scale_ext;

	// Column RAM holding the glyph of the current character.
	sgr_ram #(
		.WIDTH(GLYPH_ROWS),
		.DEPTH(GLYPH_COLS)
	) u_col_ram (
		.clk   (clk),
		.we    (state_q == ST_LOAD),
		.waddr (ld_q),
		.wdata (glyph_col(code_q, ld_q)),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (col_data)
	);

	// Clipping of the current dot's square on both axes.
	sgr_clip u_clip_x (
		.start (px_q),
		.len   (scale_q),
		.limit (POS_W'(SCREEN_W)),
		.span  (span_x)
	);

	sgr_clip u_clip_y (
		.start (py_q),
		.len   (scale_q),
		.limit (POS_W'(SCREEN_H)),
		.span  (span_y)
	);

	// Scan control and case fold of the request code: a visible dot stalls only when the held square cannot move out.
	always_comb begin
		req_code  = req.char_code;
		if (req.char_code >= CHAR_LOWER_A && req.char_code <= CHAR_LOWER_Z) begin
			req_code = req.char_code - CASE_OFFSET;
		end
		scale_ext = signed'({{(POS_W-SCALE_W){1'b0}}, scale_q});
		hit       = col_data[cy_q] && span_x.vis && span_y.vis;
		out_free  = !out_v_q || rsp.ready;
		advance   = (state_q == ST_SCAN) && !(hit && pend_v_q && !out_free);
		out_load  = (advance && hit && pend_v_q) || (state_q == ST_DONE && out_free);
		ram_re    = 1'b0;
		ram_raddr = '0;
		if (state_q == ST_LOAD && ld_q == LAST_COL) begin
			ram_re = 1'b1;
		end else if (advance && cy_q == LAST_ROW && cx_q != LAST_COL) begin
			ram_re    = 1'b1;
			ram_raddr = cx_q + COL_AW'(1);
		end
	end

	assign req.ready      = (state_q == ST_IDLE);
	assign rsp.valid      = out_v_q;
	assign rsp.rect_x     = out_x_q;
	assign rsp.rect_y     = out_y_q;
	assign rsp.rect_w     = out_w_q;
	assign rsp.rect_h     = out_h_q;
	assign rsp.fill_color = out_c_q;
	assign rsp.last       = out_last_q;

	// Sequencer with the held square and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			code_q     <= '0;
			oy_q       <= '0;
			px_q       <= '0;
			py_q       <= '0;
			scale_q    <= '0;
			color_q    <= '0;
			ld_q       <= '0;
			cx_q       <= '0;
			cy_q       <= '0;
			pend_v_q   <= 1'b0;
			pend_x_q   <= '0;
			pend_y_q   <= '0;
			pend_w_q   <= '0;
			pend_h_q   <= '0;
			out_v_q    <= 1'b0;
			out_x_q    <= '0;
			out_y_q    <= '0;
			out_w_q    <= '0;
			out_h_q    <= '0;
			out_c_q    <= '0;
			out_last_q <= 1'b0;
		end else begin
			// The output register takes a new square or empties once its transaction is done.
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (out_v_q && rsp.ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						code_q  <= req_code;
						px_q    <= POS_W'(req.origin_x);
						py_q    <= POS_W'(req.origin_y);
						oy_q    <= POS_W'(req.origin_y);
						scale_q <= (req.scale > MAX_SCALE) ? MAX_SCALE : req.scale;
						color_q <= req.color;
						ld_q    <= '0;
						cx_q    <= '0;
						cy_q    <= '0;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					ld_q <= ld_q + COL_AW'(1);
					if (ld_q == LAST_COL) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (advance) begin
						if (hit) begin
							if (pend_v_q) begin
								out_x_q    <= pend_x_q;
								out_y_q    <= pend_y_q;
								out_w_q    <= pend_w_q;
								out_h_q    <= pend_h_q;
								out_c_q    <= color_q;
								out_last_q <= 1'b0;
							end
							pend_v_q <= 1'b1;
							pend_x_q <= span_x.lo;
							pend_y_q <= span_y.lo;
							pend_w_q <= span_x.len;
							pend_h_q <= span_y.len;
						end
						if (cy_q == LAST_ROW) begin
							cy_q <= '0;
							py_q <= oy_q;
							cx_q <= cx_q + COL_AW'(1);
							px_q <= px_q + scale_ext;
							if (cx_q == LAST_COL) begin
								state_q <= ST_DONE;
							end
						end else begin
							cy_q <= cy_q + ROW_W'(1);
							py_q <= py_q + scale_ext;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_last_q <= 1'b1;
						out_x_q    <= pend_v_q ? pend_x_q : '0;
						out_y_q    <= pend_v_q ? pend_y_q : '0;
						out_w_q    <= pend_v_q ? pend_w_q : '0;
						out_h_q    <= pend_v_q ? pend_h_q : '0;
						out_c_q    <= pend_v_q ? color_q : '0;
						pend_v_q   <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// No square is held back between characters.
	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_v_q)
		else $error("held square left over in idle");

	// Only the empty closing result has zero width, and it carries last.
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_w_q == '0) |-> (out_last_q && out_h_q == '0 && out_c_q == '0))
		else $error("empty result without last");

	// Every visible square lies on screen and is no larger than one dot.
	a_rect_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(out_v_q && out_w_q != '0) |-> (int'(out_x_q) < SCREEN_W
		&& int'(out_y_q) < SCREEN_H && out_w_q <= MAX_SCALE && out_h_q <= MAX_SCALE))
		else $error("square outside screen or oversized");

	// An accepted request starts the glyph load.
	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready) |=> (state_q == ST_LOAD && ld_q == '0))
		else $error("request accepted without glyph load");
endmodule
